FILE: rtl/qrf_pkg.sv
`default_nettype none
package qrf_pkg;

   localparam int FRAC = 40;
   localparam int MAX_STEPS = 62;
   localparam int STEP_W = $clog2(MAX_STEPS + 1);
   localparam int PT_W = 48;
   localparam int VAL_W = 64;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   typedef logic signed [PT_W-1:0] point_type;
   typedef logic signed [VAL_W-1:0] value_type;

   localparam logic [1:0] M_BISECT = 2'd0;
   localparam logic [1:0] M_NEWTON = 2'd1;
   localparam logic [1:0] M_SECANT = 2'd2;
   localparam logic [1:0] M_NONE = 2'd3;

   localparam logic [1:0] R_CONVERGED = 2'd0;
   localparam logic [1:0] R_ZERO_DIV = 2'd1;
   localparam logic [1:0] R_STEP_CAP = 2'd2;
   localparam logic [1:0] R_OVERFLOW = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_CONST = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_LINEAR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_SQUARE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_CUBE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_FOURTH = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PRECISION = 3'd5;

   localparam value_type P48_MAX = value_type'({1'b0, {(PT_W-1){1'b1}}});
   localparam value_type P48_MIN = -P48_MAX - 64'sd1;
   localparam logic signed [64:0] VMAX65 = {2'b00, {63{1'b1}}};
   localparam logic signed [71:0] VMAX72 = {9'b0, {63{1'b1}}};

   function automatic point_type sat48(value_type v);
      if (v > P48_MAX) return point_type'(P48_MAX);
      else if (v < P48_MIN) return point_type'(P48_MIN);
      else return point_type'(v);
   endfunction

   localparam value_type ONE_V = 64'sd1 <<< FRAC;
   localparam point_type P_ONE = sat48(ONE_V);
   localparam point_type P_HALF = sat48(ONE_V >>> 1);
   localparam point_type P_04 = sat48((64'sd4 * ONE_V + 64'sd5) / 64'sd10);
   localparam point_type P_08 = sat48((64'sd8 * ONE_V + 64'sd5) / 64'sd10);

   typedef struct packed {
      logic signed [15:0] c_const;
      logic signed [15:0] c_linear;
      logic signed [15:0] c_square;
      logic signed [15:0] c_cube;
      logic signed [15:0] c_fourth;
      logic [3:0] prec;
   } csr_type;

   typedef struct packed {
      point_type estimate;
      logic is_value;
      logic [1:0] stop_reason;
      logic last;
   } item_type;

   typedef struct packed {
      logic start;
      logic mul_only;
      value_type a;
      value_type b;
      value_type c;
   } md_req_type;

   typedef struct packed {
      logic done;
      logic ovf;
      value_type res;
      logic [127:0] prod;
   } md_rsp_type;

   function automatic item_type value_item(point_type p);
      item_type it;
      it.estimate = p;
      it.is_value = 1'b1;
      it.stop_reason = R_CONVERGED;
      it.last = 1'b0;
      return it;
   endfunction

   function automatic item_type status_item(logic [1:0] r);
      item_type it;
      it.estimate = '0;
      it.is_value = 1'b0;
      it.stop_reason = r;
      it.last = 1'b1;
      return it;
   endfunction

   function automatic value_type pow10(logic [3:0] d);
      case (d)
         4'd0: return 64'sd1;
         4'd1: return 64'sd10;
         4'd2: return 64'sd100;
         4'd3: return 64'sd1000;
         4'd4: return 64'sd10000;
         4'd5: return 64'sd100000;
         4'd6: return 64'sd1000000;
         4'd7: return 64'sd10000000;
         4'd8: return 64'sd100000000;
         4'd9: return 64'sd1000000000;
         default: return 64'sd10000000000;
      endcase
   endfunction

endpackage
`default_nettype wire

FILE: rtl/qrf_req_if.sv
`default_nettype none
interface qrf_req_if;
   logic valid;
   logic ready;
   logic [1:0] method;
   modport source(output valid, output method, input ready);
   modport sink(input valid, input method, output ready);
endinterface
`default_nettype wire

FILE: rtl/qrf_rsp_if.sv
`default_nettype none
interface qrf_rsp_if
   import qrf_pkg::*;
;
   logic valid;
   logic ready;
   point_type estimate;
   logic is_value;
   logic [1:0] stop_reason;
   logic last;
   modport source(output valid, output estimate, output is_value, output stop_reason,
      output last, input ready);
   modport sink(input valid, input estimate, input is_value, input stop_reason,
      input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/qrf_muldiv.sv
`default_nettype none
module qrf_muldiv
   import qrf_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  md_req_type md_req,
   output md_rsp_type md_rsp
);

   typedef enum logic [3:0] {
      U_IDLE = 4'b0001,
      U_MUL  = 4'b0010,
      U_DIV  = 4'b0100,
      U_DONE = 4'b1000
   } ustate_type;

   ustate_type st_ff, st_in;
   logic [63:0] am_ff, am_in, bm_ff, bm_in, cm_ff, cm_in;
   logic neg_ff, neg_in, mo_ff, mo_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [63:0] pp_ff, pp_in;
   logic [127:0] prod_ff, prod_in;
   logic [63:0] rem_ff, rem_in, dlo_ff, dlo_in, q_ff, q_in;
   value_type res_ff, res_in;
   logic ovf_ff, ovf_in;

   logic [31:0] opa, opb;
   logic [127:0] pp_sh;
   logic [64:0] sh;
   logic [64:0] sh_sub;
   logic qb;
   logic [63:0] q_next;

   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0: begin opa = am_ff[31:0]; opb = bm_ff[31:0]; end
         2'd1: begin opa = am_ff[31:0]; opb = bm_ff[63:32]; end
         2'd2: begin opa = am_ff[63:32]; opb = bm_ff[31:0]; end
         default: begin opa = am_ff[63:32]; opb = bm_ff[63:32]; end
      endcase
      unique case (cnt_ff[2:0])
         3'd1: pp_sh = {64'b0, pp_ff};
         3'd2, 3'd3: pp_sh = {32'b0, pp_ff, 32'b0};
         default: pp_sh = {pp_ff, 64'b0};
      endcase
      sh = {rem_ff, dlo_ff[63]};
      sh_sub = sh - {1'b0, cm_ff};
      qb = (sh >= {1'b0, cm_ff});
      q_next = {q_ff[62:0], qb};
   end

   always_comb begin
      st_in = st_ff;
      am_in = am_ff;
      bm_in = bm_ff;
      cm_in = cm_ff;
      neg_in = neg_ff;
      mo_in = mo_ff;
      cnt_in = cnt_ff;
      pp_in = pp_ff;
      prod_in = prod_ff;
      rem_in = rem_ff;
      dlo_in = dlo_ff;
      q_in = q_ff;
      res_in = res_ff;
      ovf_in = ovf_ff;
      unique case (st_ff)
         U_IDLE: begin
            if (md_req.start) begin
               am_in = md_req.a[63] ? 64'(-md_req.a) : 64'(md_req.a);
               bm_in = md_req.b[63] ? 64'(-md_req.b) : 64'(md_req.b);
               cm_in = md_req.c[63] ? 64'(-md_req.c) : 64'(md_req.c);
               neg_in = md_req.a[63] ^ md_req.b[63] ^ md_req.c[63];
               mo_in = md_req.mul_only;
               cnt_in = '0;
               prod_in = '0;
               st_in = U_MUL;
            end
         end
         U_MUL: begin
            if (cnt_ff < 6'd4) pp_in = opa * opb;
            if (cnt_ff != 6'd0) prod_in = prod_ff + pp_sh;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd4) begin
               res_in = '0;
               ovf_in = 1'b0;
               cnt_in = '0;
               if (mo_ff) begin
                  st_in = U_DONE;
               end else if (cm_ff == 64'd0 || prod_in[127:64] >= cm_ff) begin
                  ovf_in = 1'b1;
                  st_in = U_DONE;
               end else begin
                  rem_in = prod_in[127:64];
                  dlo_in = prod_in[63:0];
                  q_in = '0;
                  st_in = U_DIV;
               end
            end
         end
         U_DIV: begin
            rem_in = qb ? sh_sub[63:0] : sh[63:0];
            dlo_in = {dlo_ff[62:0], 1'b0};
            q_in = q_next;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               if (q_next[63]) begin
                  ovf_in = 1'b1;
                  res_in = '0;
               end else begin
                  res_in = neg_ff ? -value_type'(q_next) : value_type'(q_next);
               end
               st_in = U_DONE;
            end
         end
         U_DONE: st_in = U_IDLE;
         default: st_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= U_IDLE;
      end else begin
         st_ff <= st_in;
      end
      am_ff <= am_in;
      bm_ff <= bm_in;
      cm_ff <= cm_in;
      neg_ff <= neg_in;
      mo_ff <= mo_in;
      cnt_ff <= cnt_in;
      pp_ff <= pp_in;
      prod_ff <= prod_in;
      rem_ff <= rem_in;
      dlo_ff <= dlo_in;
      q_ff <= q_in;
      res_ff <= res_in;
      ovf_ff <= ovf_in;
   end

   assign md_rsp.done = (st_ff == U_DONE);
   assign md_rsp.ovf = ovf_ff;
   assign md_rsp.res = res_ff;
   assign md_rsp.prod = prod_ff;

endmodule
`default_nettype wire

FILE: rtl/qrf_ctrl.sv
`default_nettype none
module qrf_ctrl
   import qrf_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  csr_type    csr,
   input  wire        start,
   input  wire [1:0]  method,
   output logic       idle,
   input  wire        out_free,
   output logic       push,
   output item_type   item,
   output md_req_type md_req,
   input  md_rsp_type md_rsp
);

   typedef enum logic [21:0] {
      ST_IDLE      = 22'h000001,
      ST_STEP      = 22'h000002,
      ST_RND_WAIT  = 22'h000004,
      ST_POLY_WAIT = 22'h000008,
      ST_DIV_WAIT  = 22'h000010,
      ST_EMIT      = 22'h000020,
      ST_FIN_OVF   = 22'h000040,
      ST_B_R2      = 22'h000080,
      ST_B_CMP     = 22'h000100,
      ST_B_P1      = 22'h000200,
      ST_B_P2      = 22'h000400,
      ST_B_UPD     = 22'h000800,
      ST_N_P2      = 22'h001000,
      ST_N_CHK     = 22'h002000,
      ST_N_SUB     = 22'h004000,
      ST_N_R2      = 22'h008000,
      ST_N_CMP     = 22'h010000,
      ST_S_R2      = 22'h020000,
      ST_S_CMP     = 22'h040000,
      ST_S_P2      = 22'h080000,
      ST_S_DIFF    = 22'h100000,
      ST_S_SUB     = 22'h200000
   } state_type;

   function automatic logic [64:0] addc(value_type a, value_type b);
      logic signed [64:0] s;
      logic o;
      s = {a[63], a} + {b[63], b};
      o = (s > VMAX65) || (s < -VMAX65);
      return {o, s[63:0]};
   endfunction

   function automatic logic [64:0] term(csr_type c, logic dsel, logic [2:0] idx);
      logic signed [18:0] k;
      logic signed [71:0] t;
      logic o;
      if (dsel) begin
         case (idx)
            3'd0: k = 19'(c.c_fourth) <<< 2;
            3'd1: k = 19'(c.c_cube) + (19'(c.c_cube) <<< 1);
            3'd2: k = 19'(c.c_square) <<< 1;
            default: k = 19'(c.c_linear);
         endcase
      end else begin
         case (idx)
            3'd0: k = 19'(c.c_fourth);
            3'd1: k = 19'(c.c_cube);
            3'd2: k = 19'(c.c_square);
            3'd3: k = 19'(c.c_linear);
            default: k = 19'(c.c_const);
         endcase
      end
      t = 72'(k) <<< FRAC;
      o = (t > VMAX72) || (t < -VMAX72);
      return {o, t[63:0]};
   endfunction

   state_type state_ff, state_in, ret_ff, ret_in;
   point_type lo_ff, lo_in, hi_ff, hi_in, cur_ff, cur_in, xn_ff, xn_in;
   point_type rx_ff, rx_in, px_ff, px_in;
   value_type acc_ff, acc_in, f1_ff, f1_in, ra_ff, ra_in, rnd_ff, rnd_in;
   value_type quot_ff, quot_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [1:0] method_ff, method_in;
   logic ovf_ff, ovf_in, psel_ff, psel_in;
   logic [2:0] idx_ff, idx_in;
   item_type item_ff, item_in;
   md_req_type md_ff, md_in;

   logic do_rnd, do_poly, do_div, do_fin;
   point_type call_x;
   logic call_sel;
   value_type div_a, div_b, div_c;
   logic [1:0] fin_reason;
   state_type call_ret;

   logic tw_ovf, t0_ovf, pa_ovf, xs_ovf, sd_ovf;
   value_type tw_val, t0_val, pa_sum, xs_val, sd_val;
   logic [127:0] rsum;
   value_type rmag;
   logic signed [48:0] msum, msum_c;
   point_type mid;
   logic xs_fits;

   assign {tw_ovf, tw_val} = term(csr, psel_ff, idx_ff);
   assign {t0_ovf, t0_val} = term(csr, call_sel, 3'd0);
   assign {pa_ovf, pa_sum} = addc(md_rsp.res, tw_val);
   assign {xs_ovf, xs_val} = addc((state_ff == ST_N_SUB) ? value_type'(cur_ff)
      : value_type'(hi_ff), -quot_ff);
   assign {sd_ovf, sd_val} = addc(acc_ff, -f1_ff);
   assign rsum = md_rsp.prod + (128'd1 << (FRAC - 1));
   assign rmag = value_type'(rsum[FRAC +: 64]);
   assign msum = {lo_ff[PT_W-1], lo_ff} + {hi_ff[PT_W-1], hi_ff};
   assign msum_c = msum + {48'b0, msum[48]};
   assign mid = msum_c[48:1];
   assign xs_fits = (xs_val[63:PT_W-1] == '0) || (xs_val[63:PT_W-1] == '1);

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      cur_in = cur_ff;
      xn_in = xn_ff;
      rx_in = rx_ff;
      px_in = px_ff;
      acc_in = acc_ff;
      f1_in = f1_ff;
      ra_in = ra_ff;
      rnd_in = rnd_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      method_in = method_ff;
      ovf_in = ovf_ff;
      psel_in = psel_ff;
      idx_in = idx_ff;
      item_in = item_ff;
      md_in = md_ff;
      md_in.start = 1'b0;
      push = 1'b0;
      do_rnd = 1'b0;
      do_poly = 1'b0;
      do_div = 1'b0;
      do_fin = 1'b0;
      call_x = lo_ff;
      call_sel = 1'b0;
      div_a = acc_ff;
      div_b = ONE_V;
      div_c = acc_ff;
      fin_reason = R_CONVERGED;
      call_ret = ST_STEP;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ovf_in = 1'b0;
               step_in = '0;
               method_in = method;
               case (method)
                  M_BISECT: begin
                     lo_in = '0;
                     hi_in = P_ONE;
                     state_in = ST_STEP;
                  end
                  M_NEWTON: begin
                     cur_in = P_HALF;
                     item_in = value_item(P_HALF);
                     ret_in = ST_STEP;
                     state_in = ST_EMIT;
                  end
                  M_SECANT: begin
                     lo_in = P_04;
                     hi_in = P_08;
                     cur_in = P_HALF;
                     item_in = value_item(P_HALF);
                     ret_in = ST_STEP;
                     state_in = ST_EMIT;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_STEP: begin
            if (step_ff == STEP_W'(MAX_STEPS)) begin
               do_fin = 1'b1;
               fin_reason = R_STEP_CAP;
            end else begin
               step_in = step_ff + STEP_W'(1);
               case (method_ff)
                  M_BISECT: begin
                     do_rnd = 1'b1; call_x = lo_ff; call_ret = ST_B_R2;
                  end
                  M_NEWTON: begin
                     do_poly = 1'b1; call_x = cur_ff; call_sel = 1'b0; call_ret = ST_N_P2;
                  end
                  default: begin
                     do_rnd = 1'b1; call_x = lo_ff; call_ret = ST_S_R2;
                  end
               endcase
            end
         end
         ST_RND_WAIT: begin
            if (md_rsp.done) begin
               rnd_in = rx_ff[PT_W-1] ? -rmag : rmag;
               state_in = ret_ff;
            end
         end
         ST_POLY_WAIT: begin
            if (md_rsp.done) begin
               acc_in = pa_sum;
               ovf_in = ovf_ff | md_rsp.ovf | pa_ovf | tw_ovf;
               if (idx_ff == (psel_ff ? 3'd3 : 3'd4)) begin
                  state_in = ret_ff;
               end else begin
                  idx_in = idx_ff + 3'd1;
                  md_in.start = 1'b1;
                  md_in.mul_only = 1'b0;
                  md_in.a = pa_sum;
                  md_in.b = value_type'(px_ff);
                  md_in.c = ONE_V;
               end
            end
         end
         ST_DIV_WAIT: begin
            if (md_rsp.done) begin
               quot_in = md_rsp.res;
               ovf_in = ovf_ff | md_rsp.ovf;
               state_in = ret_ff;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               push = 1'b1;
               state_in = ret_ff;
            end
         end
         ST_FIN_OVF: begin
            do_fin = 1'b1;
            fin_reason = R_OVERFLOW;
         end
         ST_B_R2: begin
            ra_in = rnd_ff;
            do_rnd = 1'b1; call_x = hi_ff; call_ret = ST_B_CMP;
         end
         ST_B_CMP: begin
            if (ra_ff + 64'sd1 >= rnd_ff) begin
               do_fin = 1'b1;
               fin_reason = R_CONVERGED;
            end else begin
               xn_in = mid;
               item_in = value_item(mid);
               ret_in = ST_B_P1;
               state_in = ST_EMIT;
            end
         end
         ST_B_P1: begin
            do_poly = 1'b1; call_x = xn_ff; call_sel = 1'b0; call_ret = ST_B_P2;
         end
         ST_B_P2: begin
            f1_in = acc_ff;
            do_poly = 1'b1; call_x = lo_ff; call_sel = 1'b0; call_ret = ST_B_UPD;
         end
         ST_B_UPD: begin
            if (ovf_ff) begin
               do_fin = 1'b1;
               fin_reason = R_OVERFLOW;
            end else begin
               if ((f1_ff < 0 && acc_ff > 0) || (f1_ff > 0 && acc_ff < 0)) hi_in = xn_ff;
               else lo_in = xn_ff;
               state_in = ST_STEP;
            end
         end
         ST_N_P2: begin
            f1_in = acc_ff;
            do_poly = 1'b1; call_x = cur_ff; call_sel = 1'b1; call_ret = ST_N_CHK;
         end
         ST_N_CHK: begin
            if (ovf_ff) begin
               do_fin = 1'b1;
               fin_reason = R_OVERFLOW;
            end else if (acc_ff == '0) begin
               do_fin = 1'b1;
               fin_reason = R_ZERO_DIV;
            end else begin
               do_div = 1'b1;
               div_a = f1_ff;
               div_b = ONE_V;
               div_c = acc_ff;
               call_ret = ST_N_SUB;
            end
         end
         ST_N_SUB, ST_S_SUB: begin
            if (ovf_ff || xs_ovf) begin
               do_fin = 1'b1;
               fin_reason = R_OVERFLOW;
            end else if (!xs_fits) begin
               item_in = value_item(sat48(xs_val));
               ret_in = ST_FIN_OVF;
               state_in = ST_EMIT;
            end else if (state_ff == ST_N_SUB) begin
               xn_in = point_type'(xs_val);
               do_rnd = 1'b1; call_x = cur_ff; call_ret = ST_N_R2;
            end else begin
               item_in = value_item(point_type'(xs_val));
               cur_in = point_type'(xs_val);
               lo_in = hi_ff;
               hi_in = point_type'(xs_val);
               ret_in = ST_STEP;
               state_in = ST_EMIT;
            end
         end
         ST_N_R2: begin
            ra_in = rnd_ff;
            do_rnd = 1'b1; call_x = xn_ff; call_ret = ST_N_CMP;
         end
         ST_N_CMP: begin
            if (ra_ff == rnd_ff) begin
               do_fin = 1'b1;
               fin_reason = R_CONVERGED;
            end else begin
               item_in = value_item(xn_ff);
               cur_in = xn_ff;
               ret_in = ST_STEP;
               state_in = ST_EMIT;
            end
         end
         ST_S_R2: begin
            ra_in = rnd_ff;
            do_rnd = 1'b1; call_x = hi_ff; call_ret = ST_S_CMP;
         end
         ST_S_CMP: begin
            if (ra_ff == rnd_ff) begin
               do_fin = 1'b1;
               fin_reason = R_CONVERGED;
            end else begin
               do_poly = 1'b1; call_x = lo_ff; call_sel = 1'b0; call_ret = ST_S_P2;
            end
         end
         ST_S_P2: begin
            f1_in = acc_ff;
            do_poly = 1'b1; call_x = hi_ff; call_sel = 1'b0; call_ret = ST_S_DIFF;
         end
         ST_S_DIFF: begin
            if (ovf_ff || sd_ovf) begin
               do_fin = 1'b1;
               fin_reason = R_OVERFLOW;
            end else if (sd_val == '0) begin
               do_fin = 1'b1;
               fin_reason = R_ZERO_DIV;
            end else begin
               do_div = 1'b1;
               div_a = acc_ff;
               div_b = value_type'(hi_ff) - value_type'(lo_ff);
               div_c = sd_val;
               call_ret = ST_S_SUB;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (do_rnd) begin
         rx_in = call_x;
         md_in.start = 1'b1;
         md_in.mul_only = 1'b1;
         md_in.a = value_type'(call_x);
         md_in.b = pow10(csr.prec);
         md_in.c = ONE_V;
         ret_in = call_ret;
         state_in = ST_RND_WAIT;
      end
      if (do_poly) begin
         psel_in = call_sel;
         px_in = call_x;
         acc_in = t0_val;
         ovf_in = ovf_ff | t0_ovf;
         idx_in = 3'd1;
         md_in.start = 1'b1;
         md_in.mul_only = 1'b0;
         md_in.a = t0_val;
         md_in.b = value_type'(call_x);
         md_in.c = ONE_V;
         ret_in = call_ret;
         state_in = ST_POLY_WAIT;
      end
      if (do_div) begin
         md_in.start = 1'b1;
         md_in.mul_only = 1'b0;
         md_in.a = div_a;
         md_in.b = div_b;
         md_in.c = div_c;
         ret_in = call_ret;
         state_in = ST_DIV_WAIT;
      end
      if (do_fin) begin
         item_in = status_item(fin_reason);
         ret_in = ST_IDLE;
         state_in = ST_EMIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff <= ST_IDLE;
         md_ff <= '0;
         step_ff <= '0;
         ovf_ff <= 1'b0;
         lo_ff <= '0;
         hi_ff <= '0;
         cur_ff <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         md_ff <= md_in;
         step_ff <= step_in;
         ovf_ff <= ovf_in;
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         cur_ff <= cur_in;
      end
      xn_ff <= xn_in;
      rx_ff <= rx_in;
      px_ff <= px_in;
      acc_ff <= acc_in;
      f1_ff <= f1_in;
      ra_ff <= ra_in;
      rnd_ff <= rnd_in;
      quot_ff <= quot_in;
      method_ff <= method_in;
      psel_ff <= psel_in;
      idx_ff <= idx_in;
      item_ff <= item_in;
   end

   assign idle = (state_ff == ST_IDLE);
   assign item = item_ff;
   assign md_req = md_ff;

`ifndef SYNTHESIS
   a_push_free: assert property (@(posedge clock) disable iff (reset) push |-> out_free)
      else $error("transaction pushed into a full output register");
   a_step_cap: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_W'(MAX_STEPS))
      else $error("step count past cap");
   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      (start && idle && method != M_NONE) |=> !idle)
      else $error("run did not start");
   a_md_wait: assert property (@(posedge clock) disable iff (reset)
      md_ff.start |-> (state_ff == ST_RND_WAIT || state_ff == ST_POLY_WAIT
      || state_ff == ST_DIV_WAIT))
      else $error("unit started outside a wait state");
`endif

endmodule
`default_nettype wire

FILE: rtl/quartic_root_finder.sv
`default_nettype none
// channel  direction  payload                                  transaction when
// req_if   in         method                                   valid && ready
// rsp_if   out        estimate, is_value, stop_reason, last    valid && ready
// csr_*    in         csr_index, csr_wdata                     csr_we
// Every operation runs through the shared multiply-divide unit under one sequencer:
// 32x32 partial products, then restoring division unless the request is multiply-only.
// req_if.ready is high only while no run is in progress; rsp_if stalls hold the sequencer.
// Reset is synchronous and clears control state and the coefficient registers.
module quartic_root_finder
   import qrf_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   qrf_req_if.sink              req_if,
   qrf_rsp_if.source            rsp_if,
   input  wire                  csr_we,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [CSR_DATA_W-1:0] csr_wdata
);

   csr_type csr_ff, csr_in;
   logic rsp_vld_ff, rsp_vld_in;
   item_type rsp_item_ff, rsp_item_in;

   logic idle, push, out_free, start;
   item_type item;
   md_req_type md_req;
   md_rsp_type md_rsp;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_COEF_CONST: csr_in.c_const = csr_wdata;
            CSR_COEF_LINEAR: csr_in.c_linear = csr_wdata;
            CSR_COEF_SQUARE: csr_in.c_square = csr_wdata;
            CSR_COEF_CUBE: csr_in.c_cube = csr_wdata;
            CSR_COEF_FOURTH: csr_in.c_fourth = csr_wdata;
            CSR_PRECISION: csr_in.prec = csr_wdata[3:0];
            default: csr_in = csr_ff;
         endcase
      end
   end

   assign out_free = !rsp_vld_ff || rsp_if.ready;
   assign start = req_if.valid && idle;

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      rsp_item_in = rsp_item_ff;
      if (push) begin
         rsp_vld_in = 1'b1;
         rsp_item_in = item;
      end else if (rsp_if.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '{c_const: '0, c_linear: '0, c_square: '0, c_cube: '0, c_fourth: '0,
            prec: 4'd6};
         rsp_vld_ff <= 1'b0;
      end else begin
         csr_ff <= csr_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   qrf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr_ff),
      .start    (start),
      .method   (req_if.method),
      .idle     (idle),
      .out_free (out_free),
      .push     (push),
      .item     (item),
      .md_req   (md_req),
      .md_rsp   (md_rsp)
   );

   qrf_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   assign req_if.ready = idle;
   assign rsp_if.valid = rsp_vld_ff;
   assign rsp_if.estimate = rsp_item_ff.estimate;
   assign rsp_if.is_value = rsp_item_ff.is_value;
   assign rsp_if.stop_reason = rsp_item_ff.stop_reason;
   assign rsp_if.last = rsp_item_ff.last;

endmodule
`default_nettype wire

FILE: test/quartic_root_finder_checker.sv
module quartic_root_finder_checker
   import qrf_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   input  wire                  req_ready,
   input  wire [1:0]            req_method,
   input  wire                  rsp_valid,
   input  wire                  rsp_ready,
   input  wire [PT_W-1:0]       rsp_estimate,
   input  wire                  rsp_is_value,
   input  wire [1:0]            rsp_stop_reason,
   input  wire                  rsp_last,
   input  wire                  csr_we,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [CSR_DATA_W-1:0] csr_wdata,
   output int                   failures,
   output int                   pending
);

   localparam longint VMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint PMAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint PMIN = -PMAX - 1;
   localparam longint UNIT = 64'sd1 <<< FRAC;

   logic signed [15:0] coef [5];
   logic [3:0] digits;
   bit fault;
   item_type run_items [$];

   assign pending = run_items.size();

   function automatic logic [63:0] magnitude(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint mul_div(longint a, longint b, longint c);
      logic [127:0] prod;
      logic [127:0] quo;
      logic [63:0] mc;
      bit neg;
      neg = ((a < 0) != (b < 0)) != (c < 0);
      mc = magnitude(c);
      prod = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
      if (mc == 0 || prod[127:64] >= mc) begin
         fault = 1;
         return 0;
      end
      quo = prod / {64'd0, mc};
      if (quo[63]) begin
         fault = 1;
         return 0;
      end
      return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
   endfunction

   function automatic longint add_checked(longint a, longint b);
      if ((b > 0 && a > VMAX - b) || (b < 0 && a < -VMAX - b)) begin
         fault = 1;
         return 0;
      end
      return a + b;
   endfunction

   function automatic longint horner(longint cf [5], int n, longint x);
      longint acc;
      acc = mul_div(cf[0], UNIT, 1);
      for (int i = 1; i < n; i++) begin
         acc = mul_div(acc, x, UNIT);
         acc = add_checked(acc, mul_div(cf[i], UNIT, 1));
      end
      return acc;
   endfunction

   function automatic longint decimal_round(longint x);
      logic [127:0] prod;
      logic [63:0] scale;
      logic [63:0] r;
      int d;
      d = digits > 10 ? 10 : int'(digits);
      scale = 1;
      for (int i = 0; i < d; i++) scale = scale * 10;
      prod = {64'd0, magnitude(x)} * {64'd0, scale};
      prod = prod + (128'd1 << (FRAC - 1));
      r = prod[FRAC+63:FRAC];
      return x < 0 ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint clamp48(longint v);
      return v > PMAX ? PMAX : (v < PMIN ? PMIN : v);
   endfunction

   function automatic void push_estimate(longint v);
      item_type it;
      it.estimate = point_type'(v);
      it.is_value = 1'b1;
      it.stop_reason = R_CONVERGED;
      it.last = 1'b0;
      run_items.push_back(it);
   endfunction

   function automatic void predict_run(logic [1:0] method);
      longint fw [5];
      longint dv [5];
      longint lo, hi, cur, mid, fm, fl, f, d, q, x, f1, f2, diff;
      logic [1:0] reason;
      item_type st;
      if (method == M_NONE) return;
      fw[0] = coef[CSR_COEF_FOURTH];
      fw[1] = coef[CSR_COEF_CUBE];
      fw[2] = coef[CSR_COEF_SQUARE];
      fw[3] = coef[CSR_COEF_LINEAR];
      fw[4] = coef[CSR_COEF_CONST];
      dv[0] = 4 * fw[0];
      dv[1] = 3 * fw[1];
      dv[2] = 2 * fw[2];
      dv[3] = fw[3];
      dv[4] = 0;
      fault = 0;
      reason = R_STEP_CAP;
      if (method == M_BISECT) begin
         lo = 0;
         hi = clamp48(UNIT);
         for (int s = 0; s < MAX_STEPS; s++) begin
            if (decimal_round(lo) + 1 >= decimal_round(hi)) begin
               reason = R_CONVERGED;
               break;
            end
            mid = (lo + hi) / 2;
            push_estimate(mid);
            fm = horner(fw, 5, mid);
            fl = horner(fw, 5, lo);
            if (fault) begin
               reason = R_OVERFLOW;
               break;
            end
            if ((fm < 0 && fl > 0) || (fm > 0 && fl < 0)) hi = mid;
            else lo = mid;
         end
      end else if (method == M_NEWTON) begin
         cur = clamp48(UNIT >>> 1);
         push_estimate(cur);
         for (int s = 0; s < MAX_STEPS; s++) begin
            f = horner(fw, 5, cur);
            d = horner(dv, 4, cur);
            if (fault) begin
               reason = R_OVERFLOW;
               break;
            end
            if (d == 0) begin
               reason = R_ZERO_DIV;
               break;
            end
            q = mul_div(f, UNIT, d);
            x = add_checked(cur, -q);
            if (fault) begin
               reason = R_OVERFLOW;
               break;
            end
            if (x > PMAX || x < PMIN) begin
               push_estimate(clamp48(x));
               reason = R_OVERFLOW;
               break;
            end
            if (decimal_round(cur) == decimal_round(x)) begin
               reason = R_CONVERGED;
               break;
            end
            push_estimate(x);
            cur = x;
         end
      end else begin
         lo = clamp48((4 * UNIT + 5) / 10);
         hi = clamp48((8 * UNIT + 5) / 10);
         push_estimate(clamp48(UNIT >>> 1));
         for (int s = 0; s < MAX_STEPS; s++) begin
            if (decimal_round(lo) == decimal_round(hi)) begin
               reason = R_CONVERGED;
               break;
            end
            f1 = horner(fw, 5, lo);
            f2 = horner(fw, 5, hi);
            diff = add_checked(f2, -f1);
            if (fault) begin
               reason = R_OVERFLOW;
               break;
            end
            if (diff == 0) begin
               reason = R_ZERO_DIV;
               break;
            end
            q = mul_div(f2, hi - lo, diff);
            x = add_checked(hi, -q);
            if (fault) begin
               reason = R_OVERFLOW;
               break;
            end
            if (x > PMAX || x < PMIN) begin
               push_estimate(clamp48(x));
               reason = R_OVERFLOW;
               break;
            end
            push_estimate(x);
            lo = hi;
            hi = x;
         end
      end
      st.estimate = '0;
      st.is_value = 1'b0;
      st.stop_reason = reason;
      st.last = 1'b1;
      run_items.push_back(st);
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      if (failures < 40) $display("mismatch %s: got %h, want %h", what, got, want);
      failures++;
   endtask

   initial failures = 0;

   always @(posedge clock) begin
      item_type want;
      if (reset) begin
         run_items.delete();
         for (int i = 0; i < 5; i++) coef[i] <= '0;
         digits <= 4'd6;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_PRECISION) digits <= csr_wdata[3:0];
            else if (csr_index < CSR_PRECISION) coef[csr_index] <= csr_wdata;
         end
         if (req_valid && req_ready) predict_run(req_method);
         if (rsp_valid && rsp_ready) begin
            if (run_items.size() == 0) begin
               report("unexpected transaction", rsp_estimate, 0);
            end else begin
               want = run_items.pop_front();
               if (rsp_estimate !== want.estimate)
                  report("estimate", rsp_estimate, want.estimate);
               if (rsp_is_value !== want.is_value)
                  report("is_value", rsp_is_value, want.is_value);
               if (rsp_stop_reason !== want.stop_reason)
                  report("stop_reason", rsp_stop_reason, want.stop_reason);
               if (rsp_last !== want.last)
                  report("last", rsp_last, want.last);
            end
         end
      end
   end

endmodule

FILE: test/quartic_root_finder_tb.sv
module quartic_root_finder_tb;
   import qrf_pkg::*;

   localparam longint CYCLE_LIMIT = 60000000;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int failures;
   int pending;
   longint cycles;

   qrf_req_if req_ch ();
   qrf_rsp_if rsp_ch ();

   quartic_root_finder uut (
      .clock(clock),
      .reset(reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   quartic_root_finder_checker chk (
      .clock(clock),
      .reset(reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .req_method(req_ch.method),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .rsp_estimate(rsp_ch.estimate),
      .rsp_is_value(rsp_ch.is_value),
      .rsp_stop_reason(rsp_ch.stop_reason),
      .rsp_last(rsp_ch.last),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .failures(failures),
      .pending(pending)
   );

   initial clock = 0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 150);
   endfunction

   function automatic logic [1:0] pick_method();
      if ($urandom_range(0, 19) == 0) return M_NONE;
      return 2'($urandom_range(0, 2));
   endfunction

   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic load_poly(logic [15:0] c0, logic [15:0] c1, logic [15:0] c2,
                            logic [15:0] c3, logic [15:0] c4, logic [3:0] prec);
      logic [15:0] vals [6];
      vals = '{c0, c1, c2, c3, c4, {12'd0, prec}};
      for (int i = 0; i < 6; i++) begin
         csr_we <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic start_run(logic [1:0] m);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.method <= m;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic random_phase(int count, bit wide);
      logic [15:0] c [5];
      logic [3:0] prec;
      for (int i = 0; i < 5; i++)
         c[i] = wide ? 16'($urandom) : 16'($urandom_range(0, 40) - 20);
      prec = $urandom_range(0, 3) == 0 ? 4'($urandom_range(0, 15))
                                       : 4'($urandom_range(0, 4));
      load_poly(c[0], c[1], c[2], c[3], c[4], prec);
      for (int i = 0; i < count; i++) start_run(pick_method());
      settle();
   endtask

   initial begin
      int rx_round;
      int hold;
      rsp_ch.ready = 1'b0;
      rx_round = 0;
      @(negedge reset);
      forever begin
         hold = pick_gap();
         if (rx_round == 25) hold = 4000;
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         if ($urandom_range(0, 9) == 0) repeat (300) @(posedge clock);
         else repeat ($urandom_range(1, 12)) @(posedge clock);
         rx_round++;
      end
   end

   initial begin
      cycles = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.method = M_BISECT;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero polynomial straight out of reset
      start_run(M_BISECT);
      start_run(M_NEWTON);
      start_run(M_SECANT);
      start_run(M_NONE);
      settle();

      // root at one half, full precision
      load_poly(16'hFFFF, 16'd2, 16'd0, 16'd0, 16'd0, 4'd10);
      start_run(M_BISECT);
      start_run(M_NEWTON);
      start_run(M_SECANT);
      settle();

      // extreme coefficients, digits above ten
      load_poly(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 4'hF);
      start_run(M_BISECT);
      start_run(M_NEWTON);
      start_run(M_SECANT);
      settle();
      load_poly(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 4'd0);
      start_run(M_BISECT);
      start_run(M_NEWTON);
      start_run(M_SECANT);
      settle();

      // constant only, no root: newton divisor zero
      load_poly(16'd5, 16'd0, 16'd0, 16'd0, 16'd0, 4'd3);
      start_run(M_NEWTON);
      start_run(M_SECANT);
      start_run(M_BISECT);
      settle();
      // steep quartic, then a line whose newton steps leave the point range
      load_poly(16'd1, 16'd0, 16'd0, 16'd0, 16'h8000, 4'd8);
      start_run(M_NEWTON);
      start_run(M_SECANT);
      settle();
      load_poly(16'h7FFF, 16'd1, 16'd0, 16'd0, 16'd0, 4'd5);
      start_run(M_NEWTON);
      start_run(M_SECANT);
      start_run(M_NONE);
      settle();

      for (int p = 0; p < 14; p++) random_phase(20, p % 4 == 3);

      req_ch.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (500) @(posedge clock);
      if (failures == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
